/* hdl/voxel_facet_neighbor_cycle_order_assert.svh */
// Assertion macros shared by the checker files of this block.
// Each macro takes a label, a condition, a consequence and a message.
`ifndef VOXEL_FACET_NEIGHBOR_CYCLE_ORDER_ASSERT_SVH
`define VOXEL_FACET_NEIGHBOR_CYCLE_ORDER_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define VFNCO_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the condition.
`define VFNCO_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vfnco_pkg.sv */
package vfnco_pkg;

  // Port field widths
  localparam int unsigned FIELD_BITS     = 16;
  localparam int unsigned KIND_BITS      = 3;
  localparam int unsigned NB_BITS        = 51;
  localparam int unsigned NB_KIND_LSB    = 48;
  localparam int unsigned SRC_BITS       = 2;

  // Defaults for top-level parameters
  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Axis indices
  localparam int unsigned AXIS_X = 0;
  localparam int unsigned AXIS_Y = 1;
  localparam int unsigned AXIS_Z = 2;

  // Face kinds
  localparam logic [KIND_BITS-1:0] KIND_NEG_X = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_NEG_Y = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_NEG_Z = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_POS_Z = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_POS_Y = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_POS_X = 3'd5;

  // Sign of the facet normal along its own axis
  typedef enum logic [1:0] {
    NRM_NONE,
    NRM_NEG,
    NRM_POS
  } nrm_sign_e;

  // Control part of one queued request
  typedef struct packed {
    logic [SRC_BITS-1:0] src0;
    logic [SRC_BITS-1:0] src1;
    logic [SRC_BITS-1:0] src2;
    logic [SRC_BITS-1:0] src3;
    logic                found;
    nrm_sign_e           sign;
  } slot_ctrl_t;

  // Corner offset of a facet: bit 0 is x, bit 1 is y, bit 2 is z
  function automatic logic [2:0] corner_off(input logic [KIND_BITS-1:0] kind,
                                            input logic [1:0] idx);
    logic [11:0] row;
    begin
      unique case (kind)
        KIND_NEG_X: row = {3'b000, 3'b100, 3'b110, 3'b010};
        KIND_NEG_Y: row = {3'b101, 3'b100, 3'b000, 3'b001};
        KIND_NEG_Z: row = {3'b001, 3'b000, 3'b010, 3'b011};
        KIND_POS_Z: row = {3'b100, 3'b101, 3'b111, 3'b110};
        KIND_POS_Y: row = {3'b011, 3'b010, 3'b110, 3'b111};
        KIND_POS_X: row = {3'b101, 3'b001, 3'b011, 3'b111};
        default:    row = 12'b0;
      endcase
      corner_off = row[3*idx +: 3];
    end
  endfunction

  // One component of the facet normal; unknown kinds give zero
  function automatic logic signed [1:0] normal_comp(input logic [KIND_BITS-1:0] kind,
                                                    input int unsigned axis);
    logic signed [1:0] n;
    begin
      n = 2'sd0;
      unique case (kind)
        KIND_NEG_X: if (axis == AXIS_X) n = -2'sd1;
        KIND_NEG_Y: if (axis == AXIS_Y) n = -2'sd1;
        KIND_NEG_Z: if (axis == AXIS_Z) n = -2'sd1;
        KIND_POS_Z: if (axis == AXIS_Z) n = 2'sd1;
        KIND_POS_Y: if (axis == AXIS_Y) n = 2'sd1;
        KIND_POS_X: if (axis == AXIS_X) n = 2'sd1;
        default:    n = 2'sd0;
      endcase
      normal_comp = n;
    end
  endfunction

endpackage

/* hdl/vfnco_fifo.sv */
module vfnco_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/vfnco_front.sv */
module vfnco_front #(
  parameter int unsigned COORD_BITS = vfnco_pkg::COORD_BITS_DEF
) (
  input  logic [vfnco_pkg::FIELD_BITS-1:0] facet_x_i,
  input  logic [vfnco_pkg::FIELD_BITS-1:0] facet_y_i,
  input  logic [vfnco_pkg::FIELD_BITS-1:0] facet_z_i,
  input  logic [vfnco_pkg::KIND_BITS-1:0]  facet_kind_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_zero_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_one_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_two_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_three_i,
  output vfnco_pkg::slot_ctrl_t            ctrl_o,
  output logic signed [COORD_BITS+2:0]     pa_o,
  output logic signed [COORD_BITS+2:0]     pb_o,
  output logic signed [COORD_BITS+2:0]     qa_o,
  output logic signed [COORD_BITS+2:0]     qb_o
);

  localparam int unsigned DW = COORD_BITS + 3;

  logic [vfnco_pkg::NB_BITS-1:0]   nb_raw [4];
  logic [COORD_BITS-1:0]           nb_p   [4][3];
  logic [vfnco_pkg::KIND_BITS-1:0] nb_k   [4];
  logic [COORD_BITS-1:0]           fp     [3];
  logic [2:0]                      offs   [4][4];
  logic [COORD_BITS:0]             crn    [4][4][3];
  logic [3:1]                      share;
  logic [1:0]                      opp_idx;
  logic                            found;
  logic [1:0]                      perm0, perm1, perm2, perm3;
  logic signed [DW-1:0]            fm [3];
  logic signed [DW-1:0]            am [3];
  logic signed [DW-1:0]            bm [3];
  logic signed [DW-1:0]            d  [3];
  logic signed [DW-1:0]            e  [3];
  logic signed [1:0]               fn [3];
  logic signed [1:0]               an [3];
  logic signed [1:0]               bn [3];

  assign nb_raw[0] = neighbor_zero_i;
  assign nb_raw[1] = neighbor_one_i;
  assign nb_raw[2] = neighbor_two_i;
  assign nb_raw[3] = neighbor_three_i;
  assign fp[vfnco_pkg::AXIS_X] = facet_x_i[COORD_BITS-1:0];
  assign fp[vfnco_pkg::AXIS_Y] = facet_y_i[COORD_BITS-1:0];
  assign fp[vfnco_pkg::AXIS_Z] = facet_z_i[COORD_BITS-1:0];

  // Unpack neighbours and build their corners
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      nb_k[j] = nb_raw[j][vfnco_pkg::NB_KIND_LSB +: vfnco_pkg::KIND_BITS];
      for (int c = 0; c < 3; c++) begin
        nb_p[j][c] = nb_raw[j][vfnco_pkg::FIELD_BITS*c +: COORD_BITS];
      end
      for (int i = 0; i < 4; i++) begin
        offs[j][i] = vfnco_pkg::corner_off(nb_k[j], 2'(i));
        for (int c = 0; c < 3; c++) begin
          crn[j][i][c] = {nb_p[j][c][COORD_BITS-1], nb_p[j][c]}
                       + {{COORD_BITS{1'b0}}, offs[j][i][c]};
        end
      end
    end
  end

  // Check each candidate for a corner shared with neighbour zero
  always_comb begin
    for (int j = 1; j < 4; j++) begin
      share[j] = 1'b0;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 4; k++) begin
          if ((crn[0][i][0] == crn[j][k][0]) && (crn[0][i][1] == crn[j][k][1]) &&
              (crn[0][i][2] == crn[j][k][2])) begin
            share[j] = 1'b1;
          end
        end
      end
    end
  end

  // Pick the first opposite neighbour and swap it into slot two
  always_comb begin
    if (!share[1]) begin
      opp_idx = 2'd1;
    end else if (!share[2]) begin
      opp_idx = 2'd2;
    end else if (!share[3]) begin
      opp_idx = 2'd3;
    end else begin
      opp_idx = 2'd0;
    end
    found = ~&share;
    perm0 = (opp_idx == 2'd0) ? 2'd2 : 2'd0;
    perm1 = (opp_idx == 2'd1) ? 2'd2 : 2'd1;
    perm2 = opp_idx;
    perm3 = (opp_idx == 2'd3) ? 2'd2 : 2'd3;
  end

  // Doubled midpoints and the edge vectors d and e
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fn[c] = vfnco_pkg::normal_comp(facet_kind_i, c);
      an[c] = vfnco_pkg::normal_comp(nb_k[perm0], c);
      bn[c] = vfnco_pkg::normal_comp(nb_k[perm1], c);
      fm[c] = ({{3{fp[c][COORD_BITS-1]}}, fp[c]} << 1) + {{(DW-2){fn[c][1]}}, fn[c]};
      am[c] = ({{3{nb_p[perm0][c][COORD_BITS-1]}}, nb_p[perm0][c]} << 1)
            + {{(DW-2){an[c][1]}}, an[c]};
      bm[c] = ({{3{nb_p[perm1][c][COORD_BITS-1]}}, nb_p[perm1][c]} << 1)
            + {{(DW-2){bn[c][1]}}, bn[c]};
      d[c]  = am[c] - fm[c];
      e[c]  = bm[c] - am[c];
    end
  end

  // Select the cross-product component along the facet normal
  always_comb begin
    ctrl_o.src0  = perm0;
    ctrl_o.src1  = perm1;
    ctrl_o.src2  = perm2;
    ctrl_o.src3  = perm3;
    ctrl_o.found = found;
    unique case (facet_kind_i) inside
      vfnco_pkg::KIND_NEG_X, vfnco_pkg::KIND_POS_X: begin
        pa_o = d[vfnco_pkg::AXIS_Y];
        pb_o = e[vfnco_pkg::AXIS_Z];
        qa_o = d[vfnco_pkg::AXIS_Z];
        qb_o = e[vfnco_pkg::AXIS_Y];
      end
      vfnco_pkg::KIND_NEG_Y, vfnco_pkg::KIND_POS_Y: begin
        pa_o = d[vfnco_pkg::AXIS_Z];
        pb_o = e[vfnco_pkg::AXIS_X];
        qa_o = d[vfnco_pkg::AXIS_X];
        qb_o = e[vfnco_pkg::AXIS_Z];
      end
      vfnco_pkg::KIND_NEG_Z, vfnco_pkg::KIND_POS_Z: begin
        pa_o = d[vfnco_pkg::AXIS_X];
        pb_o = e[vfnco_pkg::AXIS_Y];
        qa_o = d[vfnco_pkg::AXIS_Y];
        qb_o = e[vfnco_pkg::AXIS_X];
      end
      default: begin
        pa_o = '0;
        pb_o = '0;
        qa_o = '0;
        qb_o = '0;
      end
    endcase
    unique case (facet_kind_i) inside
      vfnco_pkg::KIND_NEG_X, vfnco_pkg::KIND_NEG_Y, vfnco_pkg::KIND_NEG_Z:
        ctrl_o.sign = vfnco_pkg::NRM_NEG;
      vfnco_pkg::KIND_POS_X, vfnco_pkg::KIND_POS_Y, vfnco_pkg::KIND_POS_Z:
        ctrl_o.sign = vfnco_pkg::NRM_POS;
      default:
        ctrl_o.sign = vfnco_pkg::NRM_NONE;
    endcase
  end

endmodule

/* hdl/vfnco_back.sv */
module vfnco_back #(
  parameter int unsigned COORD_BITS = vfnco_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vfnco_pkg::slot_ctrl_t           ctrl_i,
  input  logic signed [COORD_BITS+2:0]    pa_i,
  input  logic signed [COORD_BITS+2:0]    pb_i,
  input  logic signed [COORD_BITS+2:0]    qa_i,
  input  logic signed [COORD_BITS+2:0]    qb_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_zero_source_o,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_one_source_o,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_two_source_o,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_three_source_o,
  output logic                            opposite_found_o
);

  localparam int unsigned DW = COORD_BITS + 3;
  localparam int unsigned PW = 2 * DW;

  logic                   s1_valid_q;
  vfnco_pkg::slot_ctrl_t  s1_ctrl_q;
  logic signed [PW-1:0]   s1_p_q, s1_q_q;
  logic signed [PW-1:0]   prod_p, prod_q;
  logic signed [PW:0]     cr;
  logic                   cr_neg, cr_pos, swap13;
  logic                   s1_ready, out_free;
  logic                   out_valid_q;
  logic [vfnco_pkg::SRC_BITS-1:0] src0_q, src1_q, src2_q, src3_q;
  logic                   found_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || out_free;
  assign in_ready_o = s1_ready;

  // Products of the selected cross-product terms
  assign prod_p = pa_i * pb_i;
  assign prod_q = qa_i * qb_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_ctrl_q <= ctrl_i;
      s1_p_q    <= prod_p;
      s1_q_q    <= prod_q;
    end
  end

  // Sign test against the normal direction
  always_comb begin
    cr     = $signed({s1_p_q[PW-1], s1_p_q}) - $signed({s1_q_q[PW-1], s1_q_q});
    cr_neg = cr[PW];
    cr_pos = !cr_neg && (cr != '0);
    case (s1_ctrl_q.sign)
      vfnco_pkg::NRM_NEG: swap13 = cr_pos;
      vfnco_pkg::NRM_POS: swap13 = cr_neg;
      default:            swap13 = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_free) begin
      src0_q  <= s1_ctrl_q.src0;
      src1_q  <= swap13 ? s1_ctrl_q.src3 : s1_ctrl_q.src1;
      src2_q  <= s1_ctrl_q.src2;
      src3_q  <= swap13 ? s1_ctrl_q.src1 : s1_ctrl_q.src3;
      found_q <= s1_ctrl_q.found;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign slot_zero_source_o  = src0_q;
  assign slot_one_source_o   = src1_q;
  assign slot_two_source_o   = src2_q;
  assign slot_three_source_o = src3_q;
  assign opposite_found_o    = found_q;

endmodule

/* hdl/voxel_facet_neighbor_cycle_order.sv */
// A request passes through the queue write, the product register and the output
// register in that order; a stall on out_ready_i can hold it between them.
// Throughput: one request per cycle while out_ready_i does not stall; the queue and
// the two back stages each take one request a cycle.
// Reset: rst_ni clears the queue and all valid flags at once; no clearing pass.
module voxel_facet_neighbor_cycle_order #(
  parameter int unsigned COORD_BITS  = vfnco_pkg::COORD_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = vfnco_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [vfnco_pkg::FIELD_BITS-1:0] facet_x_i,
  input  logic [vfnco_pkg::FIELD_BITS-1:0] facet_y_i,
  input  logic [vfnco_pkg::FIELD_BITS-1:0] facet_z_i,
  input  logic [vfnco_pkg::KIND_BITS-1:0]  facet_kind_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_zero_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_one_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_two_i,
  input  logic [vfnco_pkg::NB_BITS-1:0]    neighbor_three_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_zero_source_o,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_one_source_o,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_two_source_o,
  output logic [vfnco_pkg::SRC_BITS-1:0]  slot_three_source_o,
  output logic                            opposite_found_o
);

  localparam int unsigned DW = COORD_BITS + 3;
  localparam int unsigned CW = $bits(vfnco_pkg::slot_ctrl_t);
  localparam int unsigned QW = CW + 4 * DW;

  vfnco_pkg::slot_ctrl_t  fr_ctrl, bk_ctrl;
  logic signed [DW-1:0]   fr_pa, fr_pb, fr_qa, fr_qb;
  logic signed [DW-1:0]   bk_pa, bk_pb, bk_qa, bk_qb;
  logic [QW-1:0]          q_wdata, q_rdata;
  logic                   q_valid, bk_ready;

  // Classify the request
  vfnco_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .facet_x_i       (facet_x_i),
    .facet_y_i       (facet_y_i),
    .facet_z_i       (facet_z_i),
    .facet_kind_i    (facet_kind_i),
    .neighbor_zero_i (neighbor_zero_i),
    .neighbor_one_i  (neighbor_one_i),
    .neighbor_two_i  (neighbor_two_i),
    .neighbor_three_i(neighbor_three_i),
    .ctrl_o          (fr_ctrl),
    .pa_o            (fr_pa),
    .pb_o            (fr_pb),
    .qa_o            (fr_qa),
    .qb_o            (fr_qb)
  );

  assign q_wdata = {fr_ctrl, fr_pa, fr_pb, fr_qa, fr_qb};

  // Queue between front and back
  vfnco_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .data_i (q_wdata),
    .ready_o(in_ready_o),
    .valid_o(q_valid),
    .pop_i  (bk_ready),
    .data_o (q_rdata)
  );

  assign bk_ctrl = q_rdata[QW-1 -: CW];
  assign bk_pa   = q_rdata[4*DW-1 -: DW];
  assign bk_pb   = q_rdata[3*DW-1 -: DW];
  assign bk_qa   = q_rdata[2*DW-1 -: DW];
  assign bk_qb   = q_rdata[DW-1:0];

  // Sign test and final order
  vfnco_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (q_valid),
    .in_ready_o         (bk_ready),
    .ctrl_i             (bk_ctrl),
    .pa_i               (bk_pa),
    .pb_i               (bk_pb),
    .qa_i               (bk_qa),
    .qb_i               (bk_qb),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .slot_zero_source_o (slot_zero_source_o),
    .slot_one_source_o  (slot_one_source_o),
    .slot_two_source_o  (slot_two_source_o),
    .slot_three_source_o(slot_three_source_o),
    .opposite_found_o   (opposite_found_o)
  );

endmodule

/* hdl/vfnco_checker.sv */
`include "voxel_facet_neighbor_cycle_order_assert.svh"

module vfnco_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [vfnco_pkg::SRC_BITS-1:0] slot_zero_source_o,
  input logic [vfnco_pkg::SRC_BITS-1:0] slot_one_source_o,
  input logic [vfnco_pkg::SRC_BITS-1:0] slot_two_source_o,
  input logic [vfnco_pkg::SRC_BITS-1:0] slot_three_source_o,
  input logic                           opposite_found_o
);

  // Hold a stalled result
  `VFNCO_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(slot_zero_source_o) && $stable(slot_one_source_o) && $stable(slot_three_source_o) && $stable(opposite_found_o), "stalled result changed")

  // Slots form a permutation of the four neighbours
  `VFNCO_ASSERT_NOW(a_perm, out_valid_o, (slot_zero_source_o != slot_one_source_o) && (slot_zero_source_o != slot_two_source_o) && (slot_zero_source_o != slot_three_source_o) && (slot_one_source_o != slot_two_source_o) && (slot_one_source_o != slot_three_source_o) && (slot_two_source_o != slot_three_source_o), "slot sources not a permutation")

  // Without an opposite neighbour, slots zero and two trade places
  `VFNCO_ASSERT_NOW(a_no_opp, out_valid_o && !opposite_found_o, (slot_zero_source_o == 2'd2) && (slot_two_source_o == 2'd0), "wrong order with no opposite neighbour")

  // With an opposite neighbour, neighbour zero stays in slot zero
  `VFNCO_ASSERT_NOW(a_opp, out_valid_o && opposite_found_o, (slot_zero_source_o == 2'd0) && (slot_two_source_o != 2'd0), "wrong order with an opposite neighbour")

endmodule

bind voxel_facet_neighbor_cycle_order vfnco_checker u_checker (.*);
